[rtl/core/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned MagW = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_SHIFT,
    DV_DONE
  } div_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_RED_START,
    S_GCD_DIV,
    S_GCD_WAIT,
    S_QN_WAIT,
    S_QD_START,
    S_QD_WAIT,
    S_CHECK,
    S_OUT
  } seq_state_e;

  // request to the shared divider
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  // answer of the shared divider
  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quot;
    logic [MagW-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/rau_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(MagW);

  div_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0] quo_q, quo_d;
  logic [MagW-1:0] rem_q, rem_d;
  logic [MagW-1:0] dsr_q, dsr_d;
  logic [MagW:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    trial   = {rem_q, quo_q[MagW-1]} - {1'b0, dsr_q};
    case (state_q)
      DV_IDLE, DV_DONE: begin
        if (req_i.start) begin
          quo_d   = req_i.dividend;
          rem_d   = '0;
          dsr_d   = req_i.divisor;
          cnt_d   = '0;
          state_d = DV_SHIFT;
        end else begin
          state_d = DV_IDLE;
        end
      end
      DV_SHIFT: begin
        // shift one dividend bit into the partial remainder
        if (!trial[MagW]) begin
          rem_d = trial[MagW-1:0];
          quo_d = {quo_q[MagW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[MagW-2:0], quo_q[MagW-1]};
          quo_d = {quo_q[MagW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(MagW - 1)) state_d = DV_DONE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  assign rsp_o.done = (state_q == DV_DONE);
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/core/rational_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction add, subtract, multiply, divide and reduce with gcd reduction.
// ----------------------------------------------------------------------------
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | opcode_i a_num_i a_den_i b_num_i b_den_i
// out     | out_valid_o | out_stall_i | res_num_o res_den_o status_o
//
// every divider pass runs through issue, the shift steps and done.
// a reduction takes one pass per Euclid step plus one per quotient; divide reduces twice.
// cross products use one shared 32x32 multiplier, one product per cycle,
// three products for add and subtract, two for the others.
// reset clears the sequencer; the block takes no new item until the result
// has left the output register.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic [1:0]  status_o
);

  localparam int unsigned HW = MagW / 2;

  seq_state_e      state_q, state_d;
  logic [2:0]      op_q;
  logic            pass2_q, pass2_d;
  logic            an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [HW-1:0]   an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic            p1_s_q, p1_s_d, p2_s_q, p2_s_d;
  logic [MagW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic            n_s_q, n_s_d, d_s_q, d_s_d;
  logic [MagW-1:0] n_q, n_d, d_q, d_d;
  logic [MagW-1:0] x_q, x_d, y_q, y_d;
  logic            odd_q, odd_d;
  logic [1:0]      st_q, st_d;
  logic            mul_ph_q, mul_ph_d;
  logic [31:0]     rn_q, rn_d, rd_q, rd_d;
  logic            ov_q, ov_d;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic [HW-1:0]   ma, mb;
  logic [MagW-1:0] prod;
  logic            gneg;
  logic [MagW-1:0] lim;
  logic            bn_neg_eff;

  function automatic logic [HW:0] to_sm(input logic [31:0] v);
    logic [WIDTH-1:0] f;
    logic [HW-1:0]    m;
    f = v[WIDTH-1:0];
    m = HW'(f);
    if (f[WIDTH-1]) m = HW'((HW'(1) << WIDTH) - HW'(f));
    return {f[WIDTH-1], m};
  endfunction

  function automatic logic fits(input logic s, input logic [MagW-1:0] m);
    logic [MagW-1:0] l;
    l = MagW'(1) << (WIDTH - 1);
    return s ? (m <= l) : (m < l);
  endfunction

  rau_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  // shared 32x32 multiplier, operands picked by the phase
  // the combine step reuses it for the add and subtract denominator
  assign ma   = (mul_ph_q || state_q == S_COMB) ? ad_m_q : an_m_q;
  assign mb   = (state_q == S_COMB) ? bd_m_q
              : (op_q == OP_MUL) ? (mul_ph_q ? bd_m_q : bn_m_q)
              : (op_q == OP_DIV) ? (mul_ph_q ? bn_m_q : bd_m_q)
              : (mul_ph_q ? bn_m_q : bd_m_q);
  assign prod = MagW'(ma) * MagW'(mb);
  assign lim  = MagW'(1) << (WIDTH - 1);
  assign gneg = odd_q ? d_s_q : n_s_q;
  assign bn_neg_eff = (op_q == OP_SUB) ? !bn_s_q : bn_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mul_ph_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mul_ph_q <= mul_ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= opcode_i;
      {an_s_q, an_m_q} <= to_sm(a_num_i);
      {ad_s_q, ad_m_q} <= to_sm(a_den_i);
      {bn_s_q, bn_m_q} <= to_sm(b_num_i);
      {bd_s_q, bd_m_q} <= to_sm(b_den_i);
    end
    pass2_q <= pass2_d;
    p1_s_q <= p1_s_d; p1_q <= p1_d;
    p2_s_q <= p2_s_d; p2_q <= p2_d;
    n_s_q <= n_s_d; n_q <= n_d;
    d_s_q <= d_s_d; d_q <= d_d;
    x_q <= x_d; y_q <= y_d;
    odd_q <= odd_d;
    st_q <= st_d;
    rn_q <= rn_d; rd_q <= rd_d;
    ov_q <= ov_d;
  end

  always_comb begin
    state_d  = state_q;
    mul_ph_d = mul_ph_q;
    pass2_d  = pass2_q;
    p1_s_d = p1_s_q; p1_d = p1_q;
    p2_s_d = p2_s_q; p2_d = p2_q;
    n_s_d = n_s_q; n_d = n_q;
    d_s_d = d_s_q; d_d = d_q;
    x_d = x_q; y_d = y_q;
    odd_d = odd_q;
    st_d = st_q;
    rn_d = rn_q; rd_d = rd_q;
    ov_d = ov_q;
    dreq = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d  = S_MUL;
          mul_ph_d = 1'b0;
          pass2_d  = 1'b0;
        end
      end
      S_MUL: begin
        // phase 0 forms the first product, phase 1 the second
        if (!mul_ph_q) begin
          p1_d = prod;
          case (op_q)
            OP_MUL:  p1_s_d = an_s_q ^ bn_s_q;
            default: p1_s_d = an_s_q ^ bd_s_q;
          endcase
          mul_ph_d = 1'b1;
        end else begin
          p2_d = prod;
          case (op_q)
            OP_MUL:  p2_s_d = ad_s_q ^ bd_s_q;
            OP_DIV:  p2_s_d = ad_s_q ^ bn_s_q;
            default: p2_s_d = ad_s_q ^ bn_neg_eff;
          endcase
          mul_ph_d = 1'b0;
          state_d  = S_COMB;
        end
      end
      S_COMB: begin
        case (op_q)
          OP_ADD, OP_SUB: begin
            // second product here is b_num*a_den; denominator reuses mult
            if (p1_s_q == p2_s_q) begin
              n_s_d = p1_s_q; n_d = p1_q + p2_q;
            end else if (p1_q >= p2_q) begin
              n_s_d = p1_s_q; n_d = p1_q - p2_q;
            end else begin
              n_s_d = p2_s_q; n_d = p2_q - p1_q;
            end
            d_s_d = ad_s_q ^ bd_s_q;
            d_d   = prod;
          end
          OP_MUL, OP_DIV: begin
            n_s_d = p1_s_q; n_d = p1_q;
            d_s_d = p2_s_q; d_d = p2_q;
          end
          default: begin
            n_s_d = an_s_q; n_d = MagW'(an_m_q);
            d_s_d = ad_s_q; d_d = MagW'(ad_m_q);
          end
        endcase
        state_d = S_RED_START;
      end
      S_RED_START: begin
        n_s_d = n_s_q && (n_q != '0);
        d_s_d = d_s_q && (d_q != '0);
        x_d   = n_q;
        y_d   = d_q;
        odd_d = 1'b0;
        if (n_q == '0 && d_q == '0) begin
          st_d = ST_ZERO; state_d = S_OUT;
        end else begin
          state_d = S_GCD_DIV;
        end
      end
      S_GCD_DIV: begin
        if (y_q == '0) begin
          dreq = '{start: 1'b1, dividend: n_q, divisor: x_q};
          state_d = S_QN_WAIT;
        end else begin
          dreq = '{start: 1'b1, dividend: x_q, divisor: y_q};
          state_d = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (drsp.done) begin
          x_d = y_q; y_d = drsp.rem; odd_d = !odd_q;
          state_d = S_GCD_DIV;
        end
      end
      S_QN_WAIT: begin
        // signs stay untouched until both quotients are in, gcd sign reads them
        if (drsp.done) begin
          n_d = drsp.quot;
          state_d = S_QD_START;
        end
      end
      S_QD_START: begin
        dreq = '{start: 1'b1, dividend: d_q, divisor: x_q};
        state_d = S_QD_WAIT;
      end
      S_QD_WAIT: begin
        if (drsp.done) begin
          d_d = drsp.quot;
          d_s_d = (d_s_q != gneg) && (drsp.quot != '0);
          n_s_d = (n_s_q != gneg) && (n_q != '0);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!fits(n_s_q, n_q) || !fits(d_s_q, d_q)) begin
          st_d = ST_OVF; state_d = S_OUT;
        end else if (op_q == OP_DIV && !pass2_q) begin
          pass2_d = 1'b1; state_d = S_RED_START;
        end else begin
          st_d = ST_OK; state_d = S_OUT;
          rn_d = 32'($signed(n_s_q ? (MagW'(0) - n_q) : n_q));
          rd_d = 32'($signed(d_s_q ? (MagW'(0) - d_q) : d_q));
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    ov_d = (lim == '0);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign res_num_o   = (st_q == ST_OK) ? rn_q : 32'd0;
  assign res_den_o   = (st_q == ST_OK) ? rd_q : 32'd0;
  assign status_o    = ov_q ? ST_OVF : st_q;

endmodule
